FILE: rtl/sfr_pkg.sv
// Shared types, constants and register codes for the serial frame receiver.
package sfr_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned POS_W    = 4;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned RSP_W    = 2 * BYTE_W + WORD_W;

   // Frame positions
   localparam logic [POS_W-1:0] POS_START    = 4'd0;
   localparam logic [POS_W-1:0] POS_VERSION  = 4'd1;
   localparam logic [POS_W-1:0] POS_LENGTH   = 4'd2;
   localparam logic [POS_W-1:0] POS_COMMAND  = 4'd3;
   localparam logic [POS_W-1:0] POS_FEEDBACK = 4'd4;
   localparam logic [POS_W-1:0] POS_PARAM_HI = 4'd5;
   localparam logic [POS_W-1:0] POS_PARAM_LO = 4'd6;
   localparam logic [POS_W-1:0] POS_CSUM_HI  = 4'd7;
   localparam logic [POS_W-1:0] POS_CSUM_LO  = 4'd8;
   localparam logic [POS_W-1:0] POS_END      = 4'd9;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START   = 2'd0,
      CSR_VERSION = 2'd1,
      CSR_LENGTH  = 2'd2,
      CSR_END     = 2'd3
   } csr_idx_type;

   // Marker reset values
   localparam logic [BYTE_W-1:0] START_RESET   = 8'd126;
   localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd255;
   localparam logic [BYTE_W-1:0] LENGTH_RESET  = 8'd6;
   localparam logic [BYTE_W-1:0] END_RESET     = 8'd239;

   typedef struct packed {
      logic [BYTE_W-1:0] start_marker;
      logic [BYTE_W-1:0] version_marker;
      logic [BYTE_W-1:0] length_marker;
      logic [BYTE_W-1:0] end_marker;
   } markers_type;

   typedef struct packed {
      logic [WORD_W-1:0] frame_parameter;
      logic [BYTE_W-1:0] frame_feedback;
      logic [BYTE_W-1:0] frame_command;
   } frame_type;

endpackage

FILE: rtl/sfr_csr.sv
// Marker register file written through the plain configuration port.
module sfr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [sfr_pkg::BYTE_W-1:0]     csr_wdata,
   output sfr_pkg::markers_type           markers
);
   import sfr_pkg::*;

   markers_type markers_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         markers_ff.start_marker   <= START_RESET;
         markers_ff.version_marker <= VERSION_RESET;
         markers_ff.length_marker  <= LENGTH_RESET;
         markers_ff.end_marker     <= END_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_START:   markers_ff.start_marker   <= csr_wdata;
            CSR_VERSION: markers_ff.version_marker <= csr_wdata;
            CSR_LENGTH:  markers_ff.length_marker  <= csr_wdata;
            CSR_END:     markers_ff.end_marker     <= csr_wdata;
            default:     ;
         endcase
      end
   end

   assign markers = markers_ff;

endmodule

FILE: rtl/sfr_parser.sv
// Frame position tracker, checksum accumulator and field capture.
module sfr_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::markers_type        markers,
   input  logic                        byte_valid,
   input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
   output logic                        frame_valid,
   output sfr_pkg::frame_type          frame
);
   import sfr_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [WORD_W-1:0] rsum_ff, rsum_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] fb_ff, fb_in;
   logic [WORD_W-1:0] param_ff, param_in;
   logic              keep;
   logic              add;
   logic              match;
   logic [WORD_W-1:0] expect_sum;

   assign expect_sum = WORD_W'(0) - sum_ff;

   always_comb begin
      keep     = 1'b1;
      add      = 1'b1;
      match    = 1'b0;
      cmd_in   = cmd_ff;
      fb_in    = fb_ff;
      param_in = param_ff;
      rsum_in  = rsum_ff;
      unique case (pos_ff)
         POS_START: begin
            keep = (rx_byte == markers.start_marker);
            add  = 1'b0;
         end
         POS_VERSION:  keep = (rx_byte == markers.version_marker);
         POS_LENGTH:   keep = (rx_byte == markers.length_marker);
         POS_COMMAND:  cmd_in = rx_byte;
         POS_FEEDBACK: fb_in  = rx_byte;
         POS_PARAM_HI: param_in = {rx_byte, param_ff[BYTE_W-1:0]};
         POS_PARAM_LO: param_in = {param_ff[WORD_W-1:BYTE_W], rx_byte};
         POS_CSUM_HI: begin
            rsum_in = {rx_byte, {BYTE_W{1'b0}}};
            add     = 1'b0;
         end
         POS_CSUM_LO: begin
            rsum_in = {rsum_ff[WORD_W-1:BYTE_W], rx_byte};
            add     = 1'b0;
         end
         POS_END: begin
            match = (rx_byte == markers.end_marker) && (expect_sum == rsum_ff);
            keep  = 1'b0;
         end
         default: keep = 1'b0;
      endcase

      if (keep) begin
         pos_in = pos_ff + POS_W'(1);
         sum_in = add ? (sum_ff + WORD_W'(rx_byte)) : sum_ff;
      end else begin
         // restart: drop everything held for this frame
         pos_in   = POS_START;
         sum_in   = '0;
         rsum_in  = '0;
         cmd_in   = '0;
         fb_in    = '0;
         param_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= POS_START;
         sum_ff   <= '0;
         rsum_ff  <= '0;
         cmd_ff   <= '0;
         fb_ff    <= '0;
         param_ff <= '0;
      end else if (byte_valid) begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         rsum_ff  <= rsum_in;
         cmd_ff   <= cmd_in;
         fb_ff    <= fb_in;
         param_ff <= param_in;
      end
   end

   assign frame_valid           = byte_valid && match;
   assign frame.frame_command   = cmd_ff;
   assign frame.frame_feedback  = fb_ff;
   assign frame.frame_parameter = param_ff;

`ifndef NO_ASSERTIONS
   a_result_at_end: assert property (@(posedge clock) disable iff (reset)
      frame_valid |-> pos_ff == POS_END)
      else $error("frame result outside end position");
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      byte_valid && pos_ff == POS_END |=> pos_ff == POS_START && sum_ff == '0)
      else $error("parser did not restart after end byte");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      byte_valid && pos_ff <= POS_END |=> pos_ff <= POS_END)
      else $error("frame position left valid range");
`endif

endmodule

FILE: rtl/sfr_out_buf.sv
// Two-entry result buffer that decouples the parser from the result channel.
module sfr_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfr_pkg::frame_type  push_data,
   output logic                not_full,
   output logic                out_valid,
   input  logic                out_ready,
   output sfr_pkg::frame_type  out_data
);
   import sfr_pkg::*;

   logic [1:0] count_ff, count_in;
   frame_type  head_ff, head_in;
   frame_type  tail_ff, tail_in;
   logic       pop;

   assign pop = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         head_in = tail_ff;
      end
      unique case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) head_in = push_data;
            else                  tail_in = push_data;
         end
         2'b01: count_in = count_ff - 2'd1;
         2'b11: begin
            if (count_ff == 2'd1) head_in = push_data;
            else                  tail_in = push_data;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign not_full  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> not_full)
      else $error("result pushed into full buffer");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");
   a_pop_push_holds: assert property (@(posedge clock) disable iff (reset)
      push && pop |=> count_ff == $past(count_ff))
      else $error("simultaneous push and pop changed occupancy");
`endif

endmodule

FILE: rtl/serial_frame_receiver_top.sv
// Top level of the serial frame receiver: markers, parser and result buffer.
//
// Usage:
//   req_*  carries one received serial byte per transfer (req_tdata[7:0]).
//   rsp_*  carries one result per good frame: command, feedback and the
//          16-bit parameter word, packed into rsp_tdata.
//   csr_*  writes the start, version, length and end markers (index 0..3);
//          write only while no frame is in flight.
// Frames are ten bytes: start, version, length, command, feedback,
// parameter high, parameter low, checksum high, checksum low, end. A frame
// whose end byte and checksum (zero minus the sum of bytes one to six)
// match produces one result; any other frame is dropped without a trace.
// Throughput: one byte per cycle while req_tready is high.
// A good frame's result is registered in the result buffer on the end byte.
// Stall: a two-entry result buffer absorbs a stalled receiver; req_tready
//   drops only when both entries hold results not yet taken.
// Reset (synchronous): markers return to their defaults, the parser returns
//   to the start position and the result buffer empties.
module serial_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] frame_command, [15:8] frame_feedback,
                                    // [31:16] frame_parameter
   // configuration port
   input  logic        csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [7:0]  csr_wdata
);
   import sfr_pkg::*;

   markers_type markers;
   frame_type   frame;
   frame_type   rsp_frame;
   logic        byte_xfer;
   logic        frame_valid;
   logic        buf_not_full;

   // Accept a byte whenever the result buffer has room for a possible result.
   assign req_tready = buf_not_full;
   assign byte_xfer  = req_tvalid && req_tready;

   sfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .markers   (markers)
   );

   // Advance or restart the frame position on every byte transfer.
   sfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .markers     (markers),
      .byte_valid  (byte_xfer),
      .rx_byte     (req_tdata[BYTE_W-1:0]),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   // Hold good frames until the receiver takes them.
   sfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_valid),
      .push_data (frame),
      .not_full  (buf_not_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_frame)
   );

   assign rsp_tdata = RSP_W'(rsp_frame);

endmodule
